// ===== rtl/bbe_pkg.sv =====
// Shared types, constants and the reciprocal table for the edge-aware 3x3 box blur.
// No dependencies; the top level, bbe_avg and the testbench import this package.
package bbe_pkg;

   // Line buffer depth and the column counter that addresses it
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Register widths
   localparam int IMG_W_W    = 12;
   localparam int IMG_H_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   // Effective width must hold both the register value and MAX_WIDTH itself
   localparam int EFF_W      = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Item commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Pixel layout: channel 0 red, 1 green, 2 blue
   localparam int CH_W  = 8;
   localparam int N_CH  = 3;
   localparam int PIX_W = CH_W * N_CH;

   // Averaging datapath
   localparam int SUM_W       = 12;   // 9 * 255 + 4 fits
   localparam int COUNT_W     = 4;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   typedef logic [N_CH-1:0][CH_W-1:0] pixel_type;
   typedef pixel_type [2:0] column_type;   // index 0 top .. 2 bottom
   typedef column_type [2:0] window_type;  // index 0 left .. 2 right

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

   typedef struct packed {
      logic accept;
      logic mem_wr;
      logic sum_en;
      logic rsp_load;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIVIDE
   } state_type;

   // ceil(2^16 / count); exact for every dividend below 2^16 / 2
   function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] m;
      unique case (count)
         4'd2:    m = RECIP_W'(32768);
         4'd3:    m = RECIP_W'(21846);
         4'd4:    m = RECIP_W'(16384);
         4'd6:    m = RECIP_W'(10923);
         4'd9:    m = RECIP_W'(7282);
         default: m = RECIP_W'(65536);
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_aware.sv =====
// Top level of the edge-aware 3x3 box blur: sequencer, counters, window, output register.
// Depends on bbe_pkg, bbe_ram (line buffers) and bbe_avg (sum and division).
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_command, req_red, req_green, req_blue
//   rsp      out        rsp_valid/rsp_stall  rsp_red_avg, rsp_green_avg, rsp_blue_avg, rsp_last
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// An item that yields no result goes through accept (line buffer read) and write back;
// one that yields a result also goes through sum and divide. The steps are set by the single
// port pair of the line buffer memory and the sum and reciprocal multiply stages.
// The last step waits while the output register still holds an untaken result.
// Reset is synchronous; it clears the counters, window and handshake state. The line buffer
// memory is not cleared: entries read before they are written only feed masked neighbours.
// csr_ready is always high.
module box_blur_3x3_edge_aware (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red_avg,
   output logic [7:0]                        rsp_green_avg,
   output logic [7:0]                        rsp_blue_avg,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bbe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bbe_pkg::*;

   state_type            state_ff, state_in;
   ctl_type              ctl;
   logic                 rsp_free;

   logic [IMG_W_W-1:0]   width_ff;
   logic [IMG_H_W-1:0]   height_ff;
   logic [EFF_W-1:0]     w_eff;
   logic [IMG_H_W-1:0]   h_eff;

   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [IMG_H_W-1:0]   in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [IMG_H_W-1:0]   out_row_ff, out_row_in;
   window_type           win_ff, win_in;
   pixel_type            px_ff;

   logic [2*PIX_W-1:0]   rd_word;
   logic [2*PIX_W-1:0]   wr_word;
   pixel_type            rd_upper;
   pixel_type            rd_middle;

   logic                 in_col_end;
   logic                 out_col_end;
   logic                 primed;
   logic                 out_last;
   border_type           border;

   logic [CH_W-1:0]      red_q, green_q, blue_q;
   logic                 rsp_valid_ff;
   logic [CH_W-1:0]      rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                 rsp_last_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[IMG_H_W-1:0];
         endcase
      end
   end

   // Zero means one; clip the width to the line buffer depth
   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = EFF_W'(1);
      end else if (EFF_W'(width_ff) > EFF_W'(MAX_WIDTH)) begin
         w_eff = EFF_W'(MAX_WIDTH);
      end else begin
         w_eff = EFF_W'(width_ff);
      end
   end
   assign h_eff = (height_ff == '0) ? IMG_H_W'(1) : height_ff;

   // ---------------- position and border logic ----------------
   assign in_col_end  = (EFF_W'(in_col_ff) + EFF_W'(1)) >= w_eff;
   assign out_col_end = (EFF_W'(out_col_ff) + EFF_W'(1)) >= w_eff;
   // A result is due once the window center has both neighbouring rows in reach
   assign primed      = (in_row_ff >= IMG_H_W'(2)) ||
                        ((in_row_ff == IMG_H_W'(1)) && (in_col_ff != '0));

   assign border.top    = (out_row_ff != '0);
   assign border.bottom = ((IMG_H_W + 1)'(out_row_ff) + (IMG_H_W + 1)'(1)) <
                          (IMG_H_W + 1)'(h_eff);
   assign border.left   = (out_col_ff != '0);
   assign border.right  = !out_col_end;
   assign out_last      = !border.bottom && out_col_end;

   // ---------------- sequencer ----------------
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = primed ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctl.accept = req_valid;
         end
         ST_READ: begin
            ctl.mem_wr = 1'b1;
         end
         ST_SUM: begin
            ctl.sum_en = 1'b1;
         end
         ST_DIVIDE: begin
            ctl.rsp_load = rsp_free;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- line buffers ----------------
   // One memory holds both buffered rows: upper in the high half, middle in the low half.
   // Read at accept, write back in the next cycle; the sequencer keeps accesses apart.
   assign rd_upper  = rd_word[PIX_W +: PIX_W];
   assign rd_middle = rd_word[0 +: PIX_W];
   assign wr_word   = {rd_middle, px_ff};

   bbe_ram #(
      .DATA_W (2 * PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ctl.mem_wr),
      .wr_addr (in_col_ff),
      .wr_data (wr_word),
      .rd_en   (ctl.accept),
      .rd_addr (in_col_ff),
      .rd_data (rd_word)
   );

   // Drain items act as black pixels
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         px_ff <= (req_command == CMD_DRAIN) ? '0 : {req_blue, req_green, req_red};
      end
   end

   // ---------------- window and counters ----------------
   always_comb begin
      win_in     = win_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      // Shift the window left, bring in the new column, advance the input position
      if (ctl.mem_wr) begin
         win_in[0]    = win_ff[1];
         win_in[1]    = win_ff[2];
         win_in[2][0] = rd_upper;
         win_in[2][1] = rd_middle;
         win_in[2][2] = px_ff;
         if (in_col_end) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + IMG_H_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end

      // Advance the output position; the last result of a frame restarts everything
      if (ctl.rsp_load) begin
         if (out_last) begin
            win_in     = '0;
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + IMG_H_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         win_ff     <= win_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------- averaging ----------------
   bbe_avg u_avg (
      .clock   (clock),
      .sum_en  (ctl.sum_en),
      .window  (win_ff),
      .border  (border),
      .red_q   (red_q),
      .green_q (green_q),
      .blue_q  (blue_q)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_red_ff   <= red_q;
         rsp_green_ff <= green_q;
         rsp_blue_ff  <= blue_q;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_avg   = rsp_red_ff;
   assign rsp_green_avg = rsp_green_ff;
   assign rsp_blue_avg  = rsp_blue_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // The frame's last result restarts every position counter
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (ctl.rsp_load && out_last) |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("position counters not cleared after last result");

   // Never overwrite a result that is still held by the receiver
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   // Summing only follows a line buffer write back
   a_sum_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ($past(state_ff) == ST_READ && $past(primed)))
      else $error("sum stage entered without a primed window");
`endif

endmodule

// ===== rtl/bbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbe_ram #(
   parameter int DATA_W = 48,
   parameter int DEPTH  = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/bbe_avg.sv =====
// Masked 3x3 sum and rounded division by the neighbour count.
// Depends on bbe_pkg (window, border and reciprocal table).
module bbe_avg (
   input  logic                        clock,
   input  logic                        sum_en,
   input  bbe_pkg::window_type         window,
   input  bbe_pkg::border_type         border,
   output logic [bbe_pkg::CH_W-1:0]    red_q,
   output logic [bbe_pkg::CH_W-1:0]    green_q,
   output logic [bbe_pkg::CH_W-1:0]    blue_q
);
   import bbe_pkg::*;

   logic [2:0]                     col_ok;
   logic [2:0]                     row_ok;
   logic [1:0]                     n_cols;
   logic [1:0]                     n_rows;
   logic [COUNT_W-1:0]             count;
   logic [N_CH-1:0][SUM_W-1:0]     total;
   logic [2:0][N_CH-1:0][SUM_W-1:0] col_sum;
   logic [N_CH-1:0][SUM_W-1:0]     sum_ff;
   logic [RECIP_W-1:0]             recip_ff;
   logic [N_CH-1:0][CH_W-1:0]      quot;
   logic [SUM_W+RECIP_W-1:0]       prod [N_CH];

   assign col_ok = {border.right, 1'b1, border.left};
   assign row_ok = {border.bottom, 1'b1, border.top};
   assign n_cols = 2'd1 + 2'(border.left) + 2'(border.right);
   assign n_rows = 2'd1 + 2'(border.top) + 2'(border.bottom);
   assign count  = COUNT_W'(n_cols) * COUNT_W'(n_rows);

   // Sum each column first, then the three columns
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < N_CH; k++) begin
            col_sum[c][k] = '0;
            for (int r = 0; r < 3; r++) begin
               if (row_ok[r]) begin
                  col_sum[c][k] = col_sum[c][k] + SUM_W'(window[c][r][k]);
               end
            end
         end
      end
      for (int k = 0; k < N_CH; k++) begin
         total[k] = SUM_W'(count >> 1);
         for (int c = 0; c < 3; c++) begin
            if (col_ok[c]) begin
               total[k] = total[k] + col_sum[c][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff   <= total;
         recip_ff <= recip(count);
      end
   end

   // Multiply by the reciprocal; the caller registers the quotient
   always_comb begin
      for (int k = 0; k < N_CH; k++) begin
         prod[k] = (SUM_W + RECIP_W)'(sum_ff[k]) * (SUM_W + RECIP_W)'(recip_ff);
         quot[k] = prod[k][RECIP_SHIFT +: CH_W];
      end
   end

   assign red_q   = quot[0];
   assign green_q = quot[1];
   assign blue_q  = quot[2];

endmodule

// ===== bench/box_blur_3x3_edge_aware_test.sv =====
// Self-checking bench for the edge-aware 3x3 box blur: directed, random, then clamped frames.
// Depends on bbe_pkg and the box_blur_3x3_edge_aware RTL; predicts every average on its own.
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_test;
   import bbe_pkg::*;

   localparam int     RESET_CYCLES = 10;
   localparam int     HOLD_OFF     = 16;          // settle margin once no average is owed
   localparam int     RANDOM_ITEMS = 1000;
   localparam int     CLAMP_ITEMS  = 24;
   localparam longint RUN_LIMIT_NS = 50_000_000;

   // One output pixel as the block presents it
   typedef struct packed {
      logic [CH_W-1:0] red_avg;
      logic [CH_W-1:0] green_avg;
      logic [CH_W-1:0] blue_avg;
      logic            last;
   } blur_out_type;

   // Directed stimulus row; the expected output is typed in only where it is obvious
   typedef struct packed {
      logic            cmd;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            typed;
      logic [CH_W-1:0] want_red;
      logic [CH_W-1:0] want_green;
      logic [CH_W-1:0] want_blue;
      logic            want_last;
   } dir_row_type;

   localparam logic TYPED      = 1'b1;
   localparam logic FROM_MODEL = 1'b0;

   // Two 3x3 frames. The first is flat magenta, so every average is magenta and the ninth
   // output closes the frame. The second mixes extremes, a drain inside the frame (a zero
   // pixel) and pixels instead of drains after the frame, and leans on the predictor.
   localparam dir_row_type DIRECTED [26] = '{
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_DRAIN, 8'd255, 8'd255, 8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_DRAIN, 8'd255, 8'd255, 8'd255, TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_DRAIN, 8'd0,   8'd0,   8'd0,   TYPED,      8'd255, 8'd0, 8'd255, 1'b0},
      '{CMD_DRAIN, 8'd0,   8'd0,   8'd0,   TYPED,      8'd255, 8'd0, 8'd255, 1'b1},
      '{CMD_PIXEL, 8'd0,   8'd255, 8'd0,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd1,   8'd0,   8'd128, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_DRAIN, 8'd255, 8'd255, 8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd1,   8'd0,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd0,   8'd0,   8'd1,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd128, 8'd127, 8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd255, 8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd0,   8'd0,   8'd0,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd1,   8'd1,   8'd1,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd255, 8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd170, 8'd85,  8'd3,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd255, 8'd0,   8'd255, FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0},
      '{CMD_PIXEL, 8'd7,   8'd7,   8'd7,   FROM_MODEL, 8'd0,   8'd0, 8'd0,   1'b0}
   };

   // Block ports; every input is known from time zero
   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_PIXEL;
   logic [7:0]            req_red     = '0;
   logic [7:0]            req_green   = '0;
   logic [7:0]            req_blue    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [7:0]            rsp_red_avg;
   logic [7:0]            rsp_green_avg;
   logic [7:0]            rsp_blue_avg;
   logic                  rsp_last;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   // Idle rates in percent, switched per stimulus phase
   int unsigned src_idle_pct   = 9;
   int unsigned sink_stall_pct = 79;
   int unsigned mismatches     = 0;

   // Averages still owed by the block, oldest first
   blur_out_type pending_avgs [$];

   // Predictor state: register copies, the two stored rows, the 3x3 neighbourhood and the
   // input and output raster positions
   logic [IMG_W_W-1:0] cfg_width  = WIDTH_RESET;
   logic [IMG_H_W-1:0] cfg_height = HEIGHT_RESET;
   pixel_type          row_two_up [MAX_WIDTH];
   pixel_type          row_one_up [MAX_WIDTH];
   window_type         nbhd       = '0;
   int unsigned        feed_col   = 0;
   int unsigned        feed_row   = 0;
   int unsigned        emit_col   = 0;
   int unsigned        emit_row   = 0;

   box_blur_3x3_edge_aware i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_avg   (rsp_red_avg),
      .rsp_green_avg (rsp_green_avg),
      .rsp_blue_avg  (rsp_blue_avg),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Zero means one; widths beyond the line buffers clamp to their depth
   function automatic int unsigned frame_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned frame_height();
      return (cfg_height == 0) ? 1 : 32'(cfg_height);
   endfunction

   // Advance the predictor by one accepted item; return 1 when it yields an average
   function automatic bit blur_pixel(input logic cmd, input pixel_type px_in,
                                     output blur_out_type avg);
      int unsigned w, h, col, count;
      int unsigned sum [N_CH];
      pixel_type   px;
      bit          primed, top, bottom, left, right;
      avg = '0;
      w   = frame_width();
      h   = frame_height();
      // A drain enters the window as a black pixel
      px  = (cmd == CMD_PIXEL) ? px_in : '0;
      col = (feed_col >= MAX_WIDTH) ? 0 : feed_col;

      // Slide the window left, load the new column and rotate the stored rows
      nbhd[0]         = nbhd[1];
      nbhd[1]         = nbhd[2];
      nbhd[2][0]      = row_two_up[col];
      nbhd[2][1]      = row_one_up[col];
      nbhd[2][2]      = px;
      row_two_up[col] = row_one_up[col];
      row_one_up[col] = px;

      // The window is centered on a real pixel once a full row plus one has gone in
      primed = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
      if (feed_col + 1 >= w) begin
         feed_col = 0;
         if (feed_row < 65535) feed_row++;
      end else begin
         feed_col++;
      end
      if (!primed) return 1'b0;

      // Count only neighbours inside the image
      top      = emit_row > 0;
      bottom   = emit_row + 1 < h;
      left     = emit_col > 0;
      right    = emit_col + 1 < w;
      avg.last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
      count    = 0;
      for (int k = 0; k < N_CH; k++) sum[k] = 0;
      for (int c = 0; c < 3; c++) begin
         if ((c == 0 && !left) || (c == 2 && !right)) continue;
         for (int r = 0; r < 3; r++) begin
            if ((r == 0 && !top) || (r == 2 && !bottom)) continue;
            for (int k = 0; k < N_CH; k++) sum[k] += 32'(nbhd[c][r][k]);
            count++;
         end
      end
      // Round half up
      avg.red_avg   = CH_W'((sum[0] + count / 2) / count);
      avg.green_avg = CH_W'((sum[1] + count / 2) / count);
      avg.blue_avg  = CH_W'((sum[2] + count / 2) / count);

      // The last output of a frame clears the window and both raster positions
      if (avg.last) begin
         nbhd     = '0;
         feed_col = 0;
         feed_row = 0;
         emit_col = 0;
         emit_row = 0;
      end else if (emit_col + 1 >= w) begin
         emit_col = 0;
         emit_row++;
      end else begin
         emit_col++;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // Write one register; csr_ready is sampled, never assumed
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) cfg_width = data[IMG_W_W-1:0];
      else cfg_height = data[IMG_H_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one item, hold it until taken, then record what it should produce.
   // Valid is lowered only for a gap, so back-to-back items keep it high.
   task automatic send_item(input logic cmd, input pixel_type px, input logic typed,
                            input blur_out_type want);
      blur_out_type avg;
      bit           has_avg;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_red     <= px[0];
      req_green   <= px[1];
      req_blue    <= px[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_avg = blur_pixel(cmd, px, avg);
      if (typed) pending_avgs.push_back(want);
      else if (has_avg) pending_avgs.push_back(avg);
   endtask

   // Drop valid, wait for every owed average, then let an item that yields nothing finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   // Compare each taken output with the oldest owed average
   always @(posedge clock) begin
      blur_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_avgs.size() == 0) begin
            report_mismatch("unexpected output", {rsp_red_avg, rsp_green_avg}, '0);
         end else begin
            want = pending_avgs.pop_front();
            if (rsp_red_avg !== want.red_avg)
               report_mismatch("red_avg", 16'(rsp_red_avg), 16'(want.red_avg));
            if (rsp_green_avg !== want.green_avg)
               report_mismatch("green_avg", 16'(rsp_green_avg), 16'(want.green_avg));
            if (rsp_blue_avg !== want.blue_avg)
               report_mismatch("blue_avg", 16'(rsp_blue_avg), 16'(want.blue_avg));
            if (rsp_last !== want.last)
               report_mismatch("last", 16'(rsp_last), 16'(want.last));
         end
      end
   end

   initial begin
      int unsigned pick, w_reg, h_reg, n_pix, total, rand_sent;
      bit          forced_break;
      logic        cmd;
      pixel_type   px;

      for (int i = 0; i < MAX_WIDTH; i++) begin
         row_two_up[i] = '0;
         row_one_up[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at 3x3, so all of 9, 6 and 4 neighbours show up
      write_reg(CSR_IMAGE_WIDTH, 16'd3);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3);
      foreach (DIRECTED[i]) begin
         send_item(DIRECTED[i].cmd, {DIRECTED[i].blue, DIRECTED[i].green, DIRECTED[i].red},
                   DIRECTED[i].typed, {DIRECTED[i].want_red, DIRECTED[i].want_green,
                   DIRECTED[i].want_blue, DIRECTED[i].want_last});
      end

      // Random frames: mostly complete frames with a drain flush, some cut short so the
      // next size change lands mid-frame, some with zero or extreme register values
      rand_sent = 0;
      while (rand_sent < RANDOM_ITEMS) begin
         settle();
         if (rand_sent < RANDOM_ITEMS / 3) begin
            src_idle_pct   = 9;
            sink_stall_pct = 79;
         end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
            src_idle_pct   = 79;
            sink_stall_pct = 9;
         end else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
         end

         forced_break = 1'b0;
         pick = $urandom_range(99);
         if (pick < 55) begin
            w_reg = $urandom_range(6, 1);
            h_reg = $urandom_range(5, 1);
         end else if (pick < 75) begin
            w_reg = $urandom_range(24, 1);
            h_reg = $urandom_range(8, 1);
         end else if (pick < 85) begin
            // zero registers behave as one
            w_reg = $urandom_range(1) ? 0 : $urandom_range(5, 1);
            h_reg = $urandom_range(1) ? 0 : $urandom_range(5, 1);
         end else if (pick < 92) begin
            // tallest frame never finishes; cut it short
            w_reg        = $urandom_range(6, 1);
            h_reg        = 65535;
            forced_break = 1'b1;
         end else if (pick < 95) begin
            // widest frame: only a few items so no output leaves
            w_reg        = MAX_WIDTH;
            h_reg        = $urandom_range(3, 1);
            forced_break = 1'b1;
         end else begin
            w_reg = $urandom_range(4, 1);
            h_reg = $urandom_range(2, 1);
         end
         // Garbage above the 12-bit width field must be ignored
         write_reg(CSR_IMAGE_WIDTH, {4'($urandom), 12'(w_reg)});
         write_reg(CSR_IMAGE_HEIGHT, 16'(h_reg));

         n_pix = frame_width() * frame_height();
         total = n_pix + frame_width() + 1;
         if (forced_break) total = $urandom_range(40, 5);
         else if ($urandom_range(99) < 15) total = $urandom_range(total - 1, 1);

         for (int i = 0; i < total; i++) begin
            px = 24'($urandom);
            if (i < n_pix) cmd = ($urandom_range(99) < 5) ? CMD_DRAIN : CMD_PIXEL;
            else cmd = ($urandom_range(99) < 20) ? CMD_PIXEL : CMD_DRAIN;
            send_item(cmd, px, FROM_MODEL, '0);
            rand_sent++;
         end
      end

      // Width register all ones clamps to the line buffer depth; a short burst stays
      // inside the warm-up of such a row and yields nothing
      settle();
      write_reg(CSR_IMAGE_WIDTH, 16'hFFFF);
      write_reg(CSR_IMAGE_HEIGHT, 16'd1);
      for (int i = 0; i < CLAMP_ITEMS; i++) begin
         send_item(CMD_PIXEL, 24'($urandom), FROM_MODEL, '0);
      end

      settle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
